/* src/table_linear_interpolator_defines.svh */
// Assertion macros shared by the table interpolator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tli_pkg.sv */
// Shared types, codes and widths for the table interpolator.
// No dependencies; imported by every module of the block.
package tli_pkg;

   localparam int TLI_DEFAULT_DEPTH = 128;

   localparam int FUNC_W    = 2;
   localparam int RADIUS_W  = 32;
   localparam int DENSITY_W = 32;
   localparam int STATUS_W  = 2;
   localparam int PROD_W    = RADIUS_W + DENSITY_W;
   localparam int STEP_W    = $clog2(DENSITY_W);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DENSITY_W - 1);

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EDGE,
      ST_FETCH_LO,
      ST_FETCH_HI,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* src/table_linear_interpolator.sv */
// Piecewise linear interpolator over an ascending breakpoint table (sequencer top).
// Depends on tli_pkg, tli_table, tli_divider and the assertion macro header.
// Requests arrive on req_valid/req_ready with req_func, req_radius, req_density.
// Clear and append return nothing; a full table drops
// an append. A query returns one response on rsp_valid/rsp_ready carrying the
// density and a status (interpolated, clamped low, clamped high, empty table).
// A query runs a binary search with one memory read per probe (k probes, at most
// log2 of the table depth plus one), then two reads of the bracketing pair, a
// multiply and a bit-serial divide. A clamped answer skips the pair reads,
// the multiply and the divide; when the bracketing radii are not ascending the
// answer skips the multiply and the divide; an empty table also skips the search.
// req_ready is high only while no request is in progress, so queries are taken
// one at a time and a request waits until the one before it has left its last
// step; the serial divider sets the rate.
// The finished response waits in an output register: a stalled receiver does
// not stop the next request from being accepted, but a following query holds in
// its last step until the register is free. Reset empties the table and drops
// any request in progress; table contents are undefined until written.
`include "table_linear_interpolator_defines.svh"

module table_linear_interpolator #(
   parameter int TABLE_DEPTH = tli_pkg::TLI_DEFAULT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tli_pkg::FUNC_W-1:0]      req_func,
   input  logic [tli_pkg::RADIUS_W-1:0]    req_radius,
   input  logic [tli_pkg::DENSITY_W-1:0]   req_density,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tli_pkg::DENSITY_W-1:0]   rsp_density_out,
   output logic [tli_pkg::STATUS_W-1:0]    rsp_status
);
   import tli_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [RADIUS_W-1:0]  query_ff, query_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [RADIUS_W-1:0]  r0_ff, r0_in;
   logic [DENSITY_W-1:0] d0_ff, d0_in;
   logic [RADIUS_W-1:0]  span_ff, span_in;
   logic [RADIUS_W-1:0]  off_ff, off_in;
   logic [DENSITY_W-1:0] mag_ff, mag_in;
   logic                 dec_ff, dec_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [DENSITY_W-1:0] res_ff, res_in;
   logic [STATUS_W-1:0]  st_ff, st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DENSITY_W-1:0] rsp_density_ff, rsp_density_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 req_fire;
   logic                 rsp_load;
   logic [CNT_W-1:0]     half;
   logic                 probe_lt;
   logic [CNT_W-1:0]     srch_first;
   logic [CNT_W-1:0]     srch_len;
   logic [CNT_W-1:0]     srch_mid;
   logic [RADIUS_W-1:0]  off_raw;
   logic [CNT_W-1:0]     rd_addr_cnt;
   logic                 wr_en;
   logic [RADIUS_W-1:0]  rd_radius;
   logic [DENSITY_W-1:0] rd_density;
   logic                 div_start;
   logic [DENSITY_W-1:0] div_quotient;
   div_status_type       div_status;

   tli_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_radius  (req_radius),
      .wr_density (req_density),
      .rd_addr    (rd_addr_cnt[IDX_W-1:0]),
      .rd_radius  (rd_radius),
      .rd_density (rd_density)
   );

   tli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign req_fire = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      half     = len_ff >> 1;
      probe_lt = rd_radius < query_ff;
      if (probe_lt) begin
         srch_first = mid_ff + CNT_W'(1);
         srch_len   = len_ff - half - CNT_W'(1);
      end else begin
         srch_first = first_ff;
         srch_len   = half;
      end
      srch_mid = srch_first + (srch_len >> 1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_func == FUNC_QUERY) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (srch_len == '0) begin
               if (srch_first == '0 || srch_first >= count_ff) begin
                  state_in = ST_EDGE;
               end else begin
                  state_in = ST_FETCH_LO;
               end
            end
         end
         ST_EDGE:     state_in = ST_DONE;
         ST_FETCH_LO: state_in = ST_FETCH_HI;
         ST_FETCH_HI: state_in = (rd_radius <= r0_ff) ? ST_DONE : ST_MUL;
         ST_MUL:      state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      wr_en          = 1'b0;
      div_start      = 1'b0;
      rd_addr_cnt    = mid_ff;
      off_raw        = '0;
      count_in       = count_ff;
      query_in       = query_ff;
      first_in       = first_ff;
      len_in         = len_ff;
      mid_in         = mid_ff;
      r0_in          = r0_ff;
      d0_in          = d0_ff;
      span_in        = span_ff;
      off_in         = off_ff;
      mag_in         = mag_ff;
      dec_in         = dec_ff;
      prod_in        = prod_ff;
      res_in         = res_ff;
      st_in          = st_ff;
      rsp_density_in = rsp_density_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_CLEAR: count_in = '0;
                  FUNC_APPEND: begin
                     if (count_ff < DEPTH_CNT) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_QUERY: begin
                     query_in    = req_radius;
                     first_in    = '0;
                     len_in      = count_ff;
                     mid_in      = count_ff >> 1;
                     rd_addr_cnt = count_ff >> 1;
                     res_in      = '0;
                     st_in       = STATUS_EMPTY;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            first_in = srch_first;
            len_in   = srch_len;
            mid_in   = srch_mid;
            if (srch_len != '0) begin
               rd_addr_cnt = srch_mid;
            end else if (srch_first == '0) begin
               rd_addr_cnt = '0;
            end else if (srch_first >= count_ff) begin
               rd_addr_cnt = count_ff - CNT_W'(1);
            end else begin
               rd_addr_cnt = srch_first - CNT_W'(1);
            end
         end
         ST_EDGE: begin
            res_in = rd_density;
            if (first_ff == '0) begin
               st_in = (query_ff < rd_radius) ? STATUS_LOW : STATUS_INTERP;
            end else begin
               st_in = STATUS_HIGH;
            end
         end
         ST_FETCH_LO: begin
            r0_in       = rd_radius;
            d0_in       = rd_density;
            rd_addr_cnt = first_ff;
         end
         ST_FETCH_HI: begin
            span_in = rd_radius - r0_ff;
            off_raw = (query_ff > r0_ff) ? (query_ff - r0_ff) : '0;
            off_in  = (off_raw > span_in) ? span_in : off_raw;
            dec_in  = rd_density < d0_ff;
            mag_in  = dec_in ? (d0_ff - rd_density) : (rd_density - d0_ff);
            res_in  = rd_density;
            st_in   = STATUS_INTERP;
         end
         ST_MUL: begin
            prod_in = PROD_W'(off_ff) * PROD_W'(mag_ff);
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
         end
         ST_DIV_RUN: begin
            if (div_status.done) begin
               res_in = dec_ff ? (d0_ff - div_quotient) : (d0_ff + div_quotient);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_density_in = res_ff;
               rsp_status_in  = st_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff       <= query_in;
      first_ff       <= first_in;
      len_ff         <= len_in;
      mid_ff         <= mid_in;
      r0_ff          <= r0_in;
      d0_ff          <= d0_in;
      span_ff        <= span_in;
      off_ff         <= off_in;
      mag_ff         <= mag_in;
      dec_ff         <= dec_in;
      prod_ff        <= prod_in;
      res_ff         <= res_in;
      st_ff          <= st_in;
      rsp_density_ff <= rsp_density_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_density_out = rsp_density_ff;
   assign rsp_status      = rsp_status_ff;

   `TLI_ASSERT_NEXT(a_full_append_dropped, clock, reset, req_fire && req_func == FUNC_APPEND && count_ff == DEPTH_CNT, count_ff == DEPTH_CNT, "append into a full table changed the entry count")
   `TLI_ASSERT_NEXT(a_empty_query, clock, reset, req_fire && req_func == FUNC_QUERY && count_ff == '0, state_ff == ST_DONE && st_ff == STATUS_EMPTY, "query on an empty table did not finish as empty")
   `TLI_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == ST_DONE && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE, "finished query left while the response register was occupied")
   `TLI_ASSERT_SAME(a_divider_active, clock, reset, state_ff == ST_DIV_RUN, div_status.busy || div_status.done, "sequencer waits on an idle divider")

endmodule

/* src/tli_table.sv */
// Breakpoint storage: radius and density memories, one write and one read port.
// Depends on tli_pkg for field widths.
module tli_table #(
   parameter int DEPTH = tli_pkg::TLI_DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [$clog2(DEPTH)-1:0]              wr_addr,
   input  logic [tli_pkg::RADIUS_W-1:0]          wr_radius,
   input  logic [tli_pkg::DENSITY_W-1:0]         wr_density,
   input  logic [$clog2(DEPTH)-1:0]              rd_addr,
   output logic [tli_pkg::RADIUS_W-1:0]          rd_radius,
   output logic [tli_pkg::DENSITY_W-1:0]         rd_density
);
   import tli_pkg::*;

   logic [RADIUS_W-1:0]  radius_mem  [DEPTH];
   logic [DENSITY_W-1:0] density_mem [DEPTH];
   logic [RADIUS_W-1:0]  rd_radius_ff;
   logic [DENSITY_W-1:0] rd_density_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         radius_mem[wr_addr]  <= wr_radius;
         density_mem[wr_addr] <= wr_density;
      end
      rd_radius_ff  <= radius_mem[rd_addr];
      rd_density_ff <= density_mem[rd_addr];
   end

   assign rd_radius  = rd_radius_ff;
   assign rd_density = rd_density_ff;

endmodule

/* src/tli_divider.sv */
// Restoring divider that retires one quotient bit per cycle while busy.
// Depends on tli_pkg; the upper dividend half must be below the divisor.
module tli_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tli_pkg::PROD_W-1:0]     dividend,
   input  logic [tli_pkg::RADIUS_W-1:0]   divisor,
   output logic [tli_pkg::DENSITY_W-1:0]  quotient,
   output tli_pkg::div_status_type        status
);
   import tli_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [RADIUS_W-1:0]  rem_ff, rem_in;
   logic [DENSITY_W-1:0] quo_ff, quo_in;
   logic [RADIUS_W:0]    trial;
   logic [RADIUS_W:0]    diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DENSITY_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[PROD_W-1:DENSITY_W];
         quo_in  = dividend[DENSITY_W-1:0];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[RADIUS_W-1:0] : trial[RADIUS_W-1:0];
         quo_in  = {quo_ff[DENSITY_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
